// ===== rtl/kts_pkg.sv =====
// Shared types and constants for the keyframe track sampler.
package kts_pkg;

  // Field widths fixed by the item format.
  localparam int FrameW = 16;
  localparam int ValueW = 16;
  localparam int IndexW = 6;
  localparam int CountW = 7;
  localparam int MagW   = ValueW + 1;
  localparam int ProdW  = FrameW + MagW;

  // The divider needs one step per quotient bit.
  localparam int DivSteps = MagW;
  localparam int DivCntW  = $clog2(DivSteps + 1);

  // Configuration register indexes.
  typedef enum logic {
    CFG_KEY_COUNT = 1'b0,
    CFG_INTERP_EN = 1'b1
  } cfg_idx_e;

  // Item operation codes.
  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_SAMPLE = 1'b1
  } op_e;

  // Request into the multiply-divide unit.
  typedef struct packed {
    logic              start;
    logic [FrameW-1:0] num;
    logic [FrameW-1:0] den;
    logic [MagW-1:0]   mag;
  } kts_div_req_t;

  // Response from the multiply-divide unit.
  typedef struct packed {
    logic            done;
    logic [MagW-1:0] quot;
  } kts_div_rsp_t;

endpackage

// ===== rtl/kts_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module kts_ram #(
  parameter int Width = 32,
  parameter int Depth = 64,
  parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/kts_div.sv =====
// Multiply then restoring divide unit: trunc(num * mag / den), num < den.
module kts_div (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  kts_pkg::kts_div_req_t req_i,
  output kts_pkg::kts_div_rsp_t rsp_o
);

  import kts_pkg::*;

  typedef enum logic [2:0] {
    DS_IDLE = 3'b001,
    DS_MUL  = 3'b010,
    DS_STEP = 3'b100
  } div_state_e;

  div_state_e         state_q, state_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic               done_q, done_d;
  logic [FrameW-1:0]  num_q, den_q, rem_q, rem_d;
  logic [MagW-1:0]    mag_q, quot_q, quot_d;
  logic [ProdW-1:0]   prod;
  logic [MagW-1:0]    partial;
  logic [MagW-1:0]    diff;
  logic               ge;

  // The product is below den * 2**MagW, so its top bits start the remainder below den.
  assign prod    = ProdW'(num_q) * ProdW'(mag_q);
  assign partial = {rem_q, quot_q[MagW-1]};
  assign ge      = partial >= {1'b0, den_q};
  assign diff    = partial - {1'b0, den_q};

  // Sequencer: a multiply step, then one quotient bit per cycle.
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    rem_d   = rem_q;
    quot_d  = quot_q;
    unique case (state_q)
      DS_IDLE: begin
        if (req_i.start) begin
          state_d = DS_MUL;
        end
      end
      DS_MUL: begin
        rem_d   = prod[ProdW-1:MagW];
        quot_d  = prod[MagW-1:0];
        cnt_d   = DivCntW'(DivSteps);
        state_d = DS_STEP;
      end
      DS_STEP: begin
        rem_d  = ge ? diff[FrameW-1:0] : partial[FrameW-1:0];
        quot_d = {quot_q[MagW-2:0], ge};
        cnt_d  = cnt_q - DivCntW'(1);
        if (cnt_q == DivCntW'(1)) begin
          done_d  = 1'b1;
          state_d = DS_IDLE;
        end
      end
      default: state_d = DS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DS_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  // Operand and datapath registers.
  always_ff @(posedge clk_i) begin
    if (state_q == DS_IDLE && req_i.start) begin
      num_q <= req_i.num;
      den_q <= req_i.den;
      mag_q <= req_i.mag;
    end
    rem_q  <= rem_d;
    quot_q <= quot_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;

endmodule

// ===== rtl/keyframe_track_sampler.sv =====
// Keyframe track sampler: keyframe table, sequential search and linear blend.
// A write item gives no result; busy stays low.
// A sample gives its result in the cycle after acceptance on an empty table, else after
// a search of up to min(key_count, MAX_KEYS) slots, plus a blend in the divider if needed.
// busy falls as the result shows, so the next item can start then; results never stall.
// Reset clears control state and the registers (key_count 0, interp_enable 1).
module keyframe_track_sampler #(
  parameter int MAX_KEYS = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic                                op_i,
  input  logic [kts_pkg::IndexW-1:0]          entry_index_i,
  input  logic [kts_pkg::FrameW-1:0]          entry_frame_i,
  input  logic signed [kts_pkg::ValueW-1:0]   entry_value_i,
  input  logic [kts_pkg::FrameW-1:0]          query_frame_i,
  output logic signed [kts_pkg::ValueW-1:0]   sample_value_o,
  output logic                                valid_res_o,
  output logic                                done_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic                                cfg_index_i,
  input  logic [kts_pkg::CountW-1:0]          cfg_data_i
);

  import kts_pkg::*;

  localparam int AddrW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
  localparam int NumW  = ($clog2(MAX_KEYS + 1) > CountW) ? $clog2(MAX_KEYS + 1) : CountW;
  localparam int EntW  = FrameW + ValueW;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DIV  = 3'b100
  } state_e;

  state_e             state_q, state_d;
  logic [CountW-1:0]  key_count_q;
  logic               interp_q;
  logic [NumW-1:0]    n_q, n_d, idx_q, idx_d, count_ext;
  logic               found_q, found_d;
  logic               neg_q, neg_d;
  logic [FrameW-1:0]  q_q, q_d, f0_q, f0_d;
  logic [ValueW-1:0]  v0_q, v0_d;
  logic               out_set;
  logic [ValueW-1:0]  out_value;
  logic               out_valid;
  logic               accept;
  logic               we;
  logic [AddrW-1:0]   raddr;
  logic [EntW-1:0]    wdata, rdata;
  logic [FrameW-1:0]  rd_frame;
  logic [ValueW-1:0]  rd_value;
  logic               frame_le;
  logic [MagW-1:0]    dv;
  logic [MagW-1:0]    blend;
  logic               done_q;
  logic [ValueW-1:0]  value_q;
  logic               valid_q;
  logic               div_start;
  kts_div_req_t       div_req;
  kts_div_rsp_t       div_rsp;

  assign accept    = start && !busy;
  assign busy      = (state_q != ST_IDLE);
  assign count_ext = NumW'(key_count_q);

  // Configuration registers; writes are always taken.
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_count_q <= '0;
      interp_q    <= 1'b1;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_KEY_COUNT: key_count_q <= cfg_data_i;
        CFG_INTERP_EN: interp_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Keyframe table; slots past the table depth are dropped.
  assign we    = accept && (op_e'(op_i) == OP_WRITE)
                 && (NumW'(entry_index_i) < NumW'(MAX_KEYS));
  assign wdata = {entry_frame_i, entry_value_i};
  assign raddr = (state_q == ST_SCAN && idx_q < n_q) ? AddrW'(idx_q) : '0;

  kts_ram #(
    .Width(EntW),
    .Depth(MAX_KEYS),
    .AddrW(AddrW)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(AddrW'(entry_index_i)),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign rd_frame = rdata[EntW-1:ValueW];
  assign rd_value = rdata[ValueW-1:0];
  assign frame_le = rd_frame <= q_q;

  // Distance to the following keyframe and its magnitude for the divider.
  assign dv            = {rd_value[ValueW-1], rd_value} - {v0_q[ValueW-1], v0_q};
  assign div_req.start = div_start;
  assign div_req.num   = q_q - f0_q;
  assign div_req.den   = rd_frame - f0_q;
  assign div_req.mag   = dv[MagW-1] ? (MagW'(0) - dv) : dv;

  kts_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  // The blend stays between the two keyframe values, so its low bits are exact.
  assign blend = neg_q ? ({v0_q[ValueW-1], v0_q} - div_rsp.quot)
                       : ({v0_q[ValueW-1], v0_q} + div_rsp.quot);

  // Sequencer: search the table one slot per cycle, then blend if needed.
  always_comb begin
    state_d   = state_q;
    n_d       = n_q;
    idx_d     = idx_q;
    found_d   = found_q;
    neg_d     = neg_q;
    q_d       = q_q;
    f0_d      = f0_q;
    v0_d      = v0_q;
    out_set   = 1'b0;
    out_value = '0;
    out_valid = 1'b1;
    div_start = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && op_e'(op_i) == OP_SAMPLE) begin
          if (key_count_q == '0) begin
            out_set   = 1'b1;
            out_valid = 1'b0;
          end else begin
            // Slot 0 is read at acceptance, so its data is there on the first search cycle.
            n_d     = (count_ext > NumW'(MAX_KEYS)) ? NumW'(MAX_KEYS) : count_ext;
            idx_d   = NumW'(1);
            found_d = 1'b0;
            q_d     = query_frame_i;
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (frame_le) begin
          found_d = 1'b1;
          f0_d    = rd_frame;
          v0_d    = rd_value;
          if (idx_q < n_q) begin
            idx_d = idx_q + NumW'(1);
          end else begin
            // Past the last keyframe in use.
            out_set   = 1'b1;
            out_value = rd_value;
            state_d   = ST_IDLE;
          end
        end else if (!found_q) begin
          // Query before the first keyframe.
          out_set   = 1'b1;
          out_value = rd_value;
          state_d   = ST_IDLE;
        end else if (interp_q && f0_q != q_q) begin
          neg_d     = dv[MagW-1];
          div_start = 1'b1;
          state_d   = ST_DIV;
        end else begin
          out_set   = 1'b1;
          out_value = v0_q;
          state_d   = ST_IDLE;
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          out_set   = 1'b1;
          out_value = blend[ValueW-1:0];
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      n_q     <= '0;
      idx_q   <= '0;
      found_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      n_q     <= n_d;
      idx_q   <= idx_d;
      found_q <= found_d;
      done_q  <= out_set;
    end
  end

  // Search and result payload registers.
  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    q_q   <= q_d;
    f0_q  <= f0_d;
    v0_q  <= v0_d;
    if (out_set) begin
      value_q <= out_value;
      valid_q <= out_valid;
    end
  end

  assign done_o         = done_q;
  assign sample_value_o = value_q;
  assign valid_res_o    = valid_q;

endmodule

// ===== bench/tb.sv =====
// Self-checking testbench for the keyframe track sampler.
`timescale 1ns / 100ps

module tb;
  import kts_pkg::*;

  localparam int MaxKeys    = 64;
  localparam int IdlePause  = 4;
  localparam int DrainWait  = 100;
  localparam int StallLimit = 5000;
  localparam int ItemTarget = 1400;
  localparam int DirRows    = 23;

  // One sample result as it appears on the result ports.
  typedef struct packed {
    logic signed [ValueW-1:0] value;
    logic                     valid;
  } track_res_t;

  typedef enum logic {
    ROW_CFG  = 1'b0,
    ROW_ITEM = 1'b1
  } row_kind_e;

  // One line of the directed stimulus.
  typedef struct packed {
    row_kind_e                kind;
    cfg_idx_e                 cidx;
    logic [CountW-1:0]        cdata;
    op_e                      op;
    logic [IndexW-1:0]        idx;
    logic [FrameW-1:0]        frame;
    logic signed [ValueW-1:0] value;
    logic [FrameW-1:0]        query;
    logic                     typed;
    track_res_t               res;
  } dir_row_t;

  logic                     clk_i;
  logic                     rst_ni = 1'b0;
  logic                     start = 1'b0;
  logic                     busy;
  logic                     op_i = 1'b0;
  logic [IndexW-1:0]        entry_index_i = '0;
  logic [FrameW-1:0]        entry_frame_i = '0;
  logic signed [ValueW-1:0] entry_value_i = '0;
  logic [FrameW-1:0]        query_frame_i = '0;
  logic signed [ValueW-1:0] sample_value_o;
  logic                     valid_res_o;
  logic                     done_o;
  logic                     cfg_valid_i = 1'b0;
  logic                     cfg_ready_o;
  logic                     cfg_index_i = 1'b0;
  logic [CountW-1:0]        cfg_data_i = '0;

  // Shadow copy of the keyframe table and the registers.
  logic [FrameW-1:0]        key_frames [MaxKeys];
  logic signed [ValueW-1:0] key_values [MaxKeys];
  int unsigned              cur_key_count = 0;
  bit                       cur_interp = 1'b1;

  track_res_t pending_samples [$];
  dir_row_t   dir_rows [DirRows];

  int mismatches = 0;
  int stray_results = 0;
  int results_seen = 0;
  int writes_sent = 0;
  int samples_sent = 0;
  int table_settings = 0;
  int stall_cycles = 0;
  bit quiet_phase = 1'b0;

  keyframe_track_sampler #(
    .MAX_KEYS(MaxKeys)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .op_i          (op_i),
    .entry_index_i (entry_index_i),
    .entry_frame_i (entry_frame_i),
    .entry_value_i (entry_value_i),
    .query_frame_i (query_frame_i),
    .sample_value_o(sample_value_o),
    .valid_res_o   (valid_res_o),
    .done_o        (done_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Track value at a query frame: search for the last keyframe at or before
  // it, then blend toward the next one with the quotient truncated to zero.
  function automatic track_res_t predict_track(logic [FrameW-1:0] q);
    track_res_t               r;
    int                       n;
    int                       cur;
    int                       i;
    int                       num;
    int                       den;
    int                       dv;
    int                       res;
    longint                   mag;
    bit                       found;
    logic signed [ValueW-1:0] v0;
    logic signed [ValueW-1:0] v1;
    logic [FrameW-1:0]        f0;
    logic [FrameW-1:0]        f1;
    r.value = '0;
    r.valid = 1'b0;
    if (cur_key_count == 0) return r;
    r.valid = 1'b1;
    n = (cur_key_count > MaxKeys) ? MaxKeys : int'(cur_key_count);
    cur = 0;
    found = 1'b0;
    for (i = 0; i < n; i++) begin
      if (key_frames[i] <= q) begin
        cur = i;
        found = 1'b1;
      end else begin
        break;
      end
    end
    if (!found) begin
      r.value = key_values[0];
      return r;
    end
    v0 = key_values[cur];
    f0 = key_frames[cur];
    r.value = v0;
    if (!cur_interp || cur + 1 >= n || f0 == q) return r;
    f1 = key_frames[cur+1];
    v1 = key_values[cur+1];
    if (f1 <= q) return r;
    num = int'(q) - int'(f0);
    den = int'(f1) - int'(f0);
    dv = int'(v1) - int'(v0);
    mag = (dv < 0) ? -dv : dv;
    mag = (longint'(num) * mag) / den;
    res = (dv < 0) ? int'(v0) - int'(mag) : int'(v0) + int'(mag);
    r.value = res[ValueW-1:0];
    return r;
  endfunction

  // Mostly back-to-back items, some short gaps and a few long ones.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet_phase || r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Query frames near the keys, on them, at the ends of the range or anywhere.
  function automatic logic [FrameW-1:0] pick_query(int n);
    int r;
    int lo;
    int hi;
    int t;
    r = $urandom_range(0, 99);
    if (n == 0 || r < 10) return FrameW'($urandom());
    if (r < 18) return '0;
    if (r < 26) return '1;
    if (r < 42) return key_frames[$urandom_range(0, n - 1)];
    lo = key_frames[0];
    hi = key_frames[n-1];
    if (hi < lo) begin
      t = lo;
      lo = hi;
      hi = t;
    end
    lo = (lo < 20) ? 0 : lo - 20;
    hi = (hi > 65515) ? 65535 : hi + 20;
    return FrameW'($urandom_range(hi, lo));
  endfunction

  task automatic idle_gap(int cycles);
    if (cycles > 0) begin
      start <= 1'b0;
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  // Hold off the sender until every pending sample has come back.
  task automatic drain_samples();
    start <= 1'b0;
    do @(posedge clk_i); while (pending_samples.size() != 0);
  endtask

  // Present one item and wait for the block to take it.
  task automatic send_item(op_e op, logic [IndexW-1:0] idx, logic [FrameW-1:0] frame,
                           logic signed [ValueW-1:0] value, logic [FrameW-1:0] query,
                           bit typed, track_res_t typed_res);
    op_i          <= op;
    entry_index_i <= idx;
    entry_frame_i <= frame;
    entry_value_i <= value;
    query_frame_i <= query;
    start         <= 1'b1;
    do @(posedge clk_i); while (busy);
    if (op == OP_WRITE) begin
      key_frames[idx] = frame;
      key_values[idx] = value;
      writes_sent++;
    end else begin
      pending_samples.push_back(typed ? typed_res : predict_track(query));
      samples_sent++;
    end
  endtask

  // Register write, only with the block idle and nothing in flight.
  task automatic cfg_write(cfg_idx_e idx, logic [CountW-1:0] data);
    start <= 1'b0;
    do @(posedge clk_i); while (pending_samples.size() != 0 || busy);
    repeat (IdlePause) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == CFG_KEY_COUNT) cur_key_count = data;
    else cur_interp = data[0];
  endtask

  // Load slots 0..n-1, usually in ascending frame order.
  task automatic load_table(int n, bit unsorted);
    int                       i;
    int                       fr;
    int                       r;
    logic [FrameW-1:0]        f;
    logic signed [ValueW-1:0] v;
    fr = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 400);
    for (i = 0; i < n; i++) begin
      if (unsorted) begin
        f = FrameW'($urandom());
      end else begin
        f = FrameW'(fr);
        fr += ($urandom_range(0, 9) == 0) ? $urandom_range(300, 3000) : $urandom_range(0, 200);
        if (fr > 65535) fr = 65535;
      end
      r = $urandom_range(0, 99);
      if (r < 8) v = 16'sh7FFF;
      else if (r < 16) v = 16'sh8000;
      else v = ValueW'($urandom());
      idle_gap(pick_gap());
      send_item(OP_WRITE, IndexW'(i), f, v, FrameW'($urandom()), 1'b0, '0);
    end
  endtask

  // Result checker: every strobe must match the oldest pending sample.
  always @(posedge clk_i) begin
    track_res_t want;
    if (rst_ni && done_o) begin
      results_seen++;
      if (pending_samples.size() == 0) begin
        stray_results++;
        if (mismatches + stray_results <= 10)
          $display("result with nothing pending: value %0d valid %0b",
                   sample_value_o, valid_res_o);
      end else begin
        want = pending_samples.pop_front();
        if (sample_value_o !== want.value) begin
          mismatches++;
          if (mismatches + stray_results <= 10)
            $display("sample_value mismatch: expected %0d, got %0d", want.value,
                     sample_value_o);
        end
        if (valid_res_o !== want.valid) begin
          mismatches++;
          if (mismatches + stray_results <= 10)
            $display("valid_res mismatch: expected %0b, got %0b", want.valid,
                     valid_res_o);
        end
      end
    end
  end

  // Watchdog: too many cycles without any handshake ends the run.
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o || (cfg_valid_i && cfg_ready_o)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Directed table, then random table settings with samples and stray writes.
  initial begin
    int       r;
    int       i;
    int       j;
    int       n;
    int       kc;
    int       nsamp;
    dir_row_t row;
    dir_rows = '{
      // Reset state: empty table.
      '{ROW_ITEM, CFG_KEY_COUNT, 7'd0, OP_SAMPLE, 6'd0,  16'd0,     16'sd0,      16'd0,
        1'b1, '{16'sd0, 1'b0}},
      '{ROW_ITEM, CFG_KEY_COUNT, 7'd0, OP_WRITE,  6'd0,  16'd100,   -16'sd256,   16'd0,
        1'b0, '{16'sd0, 1'b0}},
      '{ROW_ITEM, CFG_KEY_COUNT, 7'd0, OP_WRITE,  6'd1,  16'd200,   16'sd512,    16'd0,
        1'b0, '{16'sd0, 1'b0}},
      '{ROW_ITEM, CFG_KEY_COUNT, 7'd0, OP_WRITE,  6'd2,  16'd65535, -16'sd32768, 16'd0,
        1'b0, '{16'sd0, 1'b0}},
      '{ROW_ITEM, CFG_KEY_COUNT, 7'd0, OP_WRITE,  6'd63, 16'd0,     16'sd32767,  16'hFFFF,
        1'b0, '{16'sd0, 1'b0}},
      '{ROW_CFG,  CFG_KEY_COUNT, 7'd3, OP_WRITE,  6'd0,  16'd0,     16'sd0,      16'd0,
        1'b0, '{16'sd0, 1'b0}},
      // Before the first key, on a key, between keys and at the last key.
      '{ROW_ITEM, CFG_KEY_COUNT, 7'd0, OP_SAMPLE, 6'd0,  16'd0,     16'sd0,      16'd0,
        1'b1, '{-16'sd256, 1'b1}},
      '{ROW_ITEM, CFG_KEY_COUNT, 7'd0, OP_SAMPLE, 6'd0,  16'd0,     16'sd0,      16'd100,
        1'b1, '{-16'sd256, 1'b1}},
      '{ROW_ITEM, CFG_KEY_COUNT, 7'd0, OP_SAMPLE, 6'd0,  16'd0,     16'sd0,      16'd150,
        1'b0, '{16'sd0, 1'b0}},
      '{ROW_ITEM, CFG_KEY_COUNT, 7'd0, OP_SAMPLE, 6'd0,  16'd0,     16'sd0,      16'd199,
        1'b0, '{16'sd0, 1'b0}},
      '{ROW_ITEM, CFG_KEY_COUNT, 7'd0, OP_SAMPLE, 6'd0,  16'd0,     16'sd0,      16'd200,
        1'b1, '{16'sd512, 1'b1}},
      '{ROW_ITEM, CFG_KEY_COUNT, 7'd0, OP_SAMPLE, 6'd0,  16'd0,     16'sd0,      16'd201,
        1'b0, '{16'sd0, 1'b0}},
      '{ROW_ITEM, CFG_KEY_COUNT, 7'd0, OP_SAMPLE, 6'd0,  16'd0,     16'sd0,      16'd65535,
        1'b1, '{-16'sd32768, 1'b1}},
      // Hold mode returns the found key's value.
      '{ROW_CFG,  CFG_INTERP_EN, 7'd0, OP_WRITE,  6'd0,  16'd0,     16'sd0,      16'd0,
        1'b0, '{16'sd0, 1'b0}},
      '{ROW_ITEM, CFG_KEY_COUNT, 7'd0, OP_SAMPLE, 6'd0,  16'd0,     16'sd0,      16'd150,
        1'b1, '{-16'sd256, 1'b1}},
      '{ROW_CFG,  CFG_INTERP_EN, 7'd1, OP_WRITE,  6'd0,  16'd0,     16'sd0,      16'd0,
        1'b0, '{16'sd0, 1'b0}},
      // Out-of-order table: the search stops at the first key past the query.
      '{ROW_ITEM, CFG_KEY_COUNT, 7'd0, OP_WRITE,  6'd1,  16'd50,    16'sd1000,   16'd0,
        1'b0, '{16'sd0, 1'b0}},
      '{ROW_ITEM, CFG_KEY_COUNT, 7'd0, OP_SAMPLE, 6'd0,  16'd0,     16'sd0,      16'd120,
        1'b0, '{16'sd0, 1'b0}},
      '{ROW_ITEM, CFG_KEY_COUNT, 7'd0, OP_SAMPLE, 6'd0,  16'd0,     16'sd0,      16'd60,
        1'b1, '{-16'sd256, 1'b1}},
      // A single key, then back to an empty table.
      '{ROW_CFG,  CFG_KEY_COUNT, 7'd1, OP_WRITE,  6'd0,  16'd0,     16'sd0,      16'd0,
        1'b0, '{16'sd0, 1'b0}},
      '{ROW_ITEM, CFG_KEY_COUNT, 7'd0, OP_SAMPLE, 6'd0,  16'd0,     16'sd0,      16'd65535,
        1'b1, '{-16'sd256, 1'b1}},
      '{ROW_CFG,  CFG_KEY_COUNT, 7'd0, OP_WRITE,  6'd0,  16'd0,     16'sd0,      16'd0,
        1'b0, '{16'sd0, 1'b0}},
      '{ROW_ITEM, CFG_KEY_COUNT, 7'd0, OP_SAMPLE, 6'd0,  16'd0,     16'sd0,      16'd300,
        1'b1, '{16'sd0, 1'b0}}
    };

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (i = 0; i < DirRows; i++) begin
      row = dir_rows[i];
      if (row.kind == ROW_CFG) begin
        cfg_write(row.cidx, row.cdata);
      end else begin
        idle_gap(pick_gap());
        send_item(row.op, row.idx, row.frame, row.value, row.query, row.typed, row.res);
      end
    end

    // Each pass picks a table size and at times a mode, loads the table and samples it.
    while (writes_sent + samples_sent < ItemTarget) begin
      r = $urandom_range(0, 99);
      if (r < 6) kc = 0;
      else if (r < 14) kc = MaxKeys;
      else if (r < 20) kc = $urandom_range(MaxKeys + 1, 127);
      else if (r < 30) kc = $urandom_range(9, MaxKeys - 1);
      else kc = $urandom_range(1, 8);
      n = (kc > MaxKeys) ? MaxKeys : kc;
      quiet_phase = ($urandom_range(0, 3) == 0);
      cfg_write(CFG_KEY_COUNT, CountW'(kc));
      if ($urandom_range(0, 1) == 1) cfg_write(CFG_INTERP_EN, CountW'($urandom_range(0, 1)));
      table_settings++;
      load_table(n, $urandom_range(0, 7) == 0);
      nsamp = $urandom_range(4, 20);
      for (j = 0; j < nsamp; j++) begin
        if ($urandom_range(0, 49) == 0) drain_samples();
        idle_gap(pick_gap());
        if ($urandom_range(0, 9) == 0)
          send_item(OP_WRITE, IndexW'($urandom()), FrameW'($urandom()),
                    ValueW'($urandom()), FrameW'($urandom()), 1'b0, '0);
        else
          send_item(OP_SAMPLE, IndexW'($urandom()), FrameW'($urandom()),
                    ValueW'($urandom()), pick_query(n), 1'b0, '0);
      end
    end

    start <= 1'b0;
    do @(posedge clk_i); while (pending_samples.size() != 0);
    repeat (DrainWait) @(posedge clk_i);

    $display("Ran %0d keyframe writes and %0d samples over %0d table settings,",
             writes_sent, samples_sent, table_settings);
    $display("tables up to %0d keys in blend and hold modes; %0d results checked.",
             MaxKeys, results_seen);
    if (mismatches == 0 && stray_results == 0 && pending_samples.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches, %0d results with nothing pending, %0d samples never answered",
               mismatches, stray_results, pending_samples.size());
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
